FILE: src/sqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqe_pkg: shared types and codes of the stack/queue engine
// Holds the command and response payload types, the action and status codes,
// and the decoded operation codes that travel from the front end to the back end.
// ----------------------------------------------------------------------------
package sqe_pkg;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
	} sqe_cmd_t;

	typedef struct packed {
		logic signed [31:0] data;
		logic               has_data;
		logic [1:0]         status;
		logic               last;
	} sqe_rsp_t;

	localparam logic [2:0] ACT_PUSH  = 3'd0;
	localparam logic [2:0] ACT_PRINT = 3'd1;
	localparam logic [2:0] ACT_PEEK  = 3'd2;
	localparam logic [2:0] ACT_POP   = 3'd3;
	localparam logic [2:0] ACT_SWAP  = 3'd4;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_SHORT = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	typedef logic [2:0] sqe_op_t;

	localparam sqe_op_t OP_NOP   = 3'd0;
	localparam sqe_op_t OP_PUSH  = 3'd1;
	localparam sqe_op_t OP_PRINT = 3'd2;
	localparam sqe_op_t OP_PEEK  = 3'd3;
	localparam sqe_op_t OP_POP   = 3'd4;
	localparam sqe_op_t OP_SWAP  = 3'd5;

	typedef struct packed {
		sqe_op_t            op;
		logic signed [31:0] value;
	} sqe_qent_t;

	typedef struct packed {
		logic      valid;
		sqe_qent_t entry;
	} sqe_head_t;

endpackage

FILE: src/sqe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqe_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sqe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/sqe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqe_front: command intake and classification
// Accepts commands, decodes the action into an operation code and holds them
// in a two-entry queue that the back end drains at its own pace.
// ----------------------------------------------------------------------------
module sqe_front
	import sqe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  sqe_cmd_t  cmd,
	output logic      busy,
	output sqe_head_t head,
	input  logic      head_pop
);

	sqe_qent_t ent_q [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] cnt_q;
	logic      push;
	sqe_qent_t dec;

	always_comb begin
		dec.value = cmd.value;
		case (cmd.action)
			ACT_PUSH:  dec.op = OP_PUSH;
			ACT_PRINT: dec.op = OP_PRINT;
			ACT_PEEK:  dec.op = OP_PEEK;
			ACT_POP:   dec.op = OP_POP;
			ACT_SWAP:  dec.op = OP_SWAP;
			default:   dec.op = OP_NOP;
		endcase
	end

	assign busy       = (cnt_q == 2'd2);
	assign push       = start && !busy;
	assign head.valid = (cnt_q != 2'd0);
	assign head.entry = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (head_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, head_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) head_pop |-> head.valid)
		else $error("Queue popped while empty.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !head_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("Queue fill count did not follow a transfer.");

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("Queue fill count out of range.");

endmodule

FILE: src/sqe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqe_back: store state and command execution
// Owns the ring of entries, the front position, the entry count and the mode
// register, carries out each decoded command and drives the result register.
// ----------------------------------------------------------------------------
module sqe_back
	import sqe_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_data,
	input  sqe_head_t head,
	output logic      head_pop,
	output sqe_rsp_t  rsp,
	output logic      rsp_valid
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_PRINT   = 3'd1;
	localparam logic [2:0] S_SWAP_B  = 3'd2;
	localparam logic [2:0] S_SWAP_W1 = 3'd3;
	localparam logic [2:0] S_SWAP_W2 = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] front_q;
	logic [CW-1:0] cnt_q;
	logic          mode_q;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] rem_q;
	logic [31:0]   tmp_q;
	logic          pend_s1;
	logic          pend_last_s1;
	sqe_rsp_t      rsp_q;
	logic          rsp_vld_q;

	logic          take;
	logic          is_empty;
	logic          is_full;
	logic [AW-1:0] front_nx;
	logic [AW-1:0] front_pv;
	logic [AW-1:0] ptr_nx;
	logic [AW:0]   sum;
	logic [AW-1:0] tail;

	logic          imm_vld;
	logic [1:0]    imm_status;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	assign take     = head.valid && (state_q == S_IDLE) && !pend_s1;
	assign head_pop = take;
	assign is_empty = (cnt_q == '0);
	assign is_full  = (cnt_q == FULL_CNT);
	assign front_nx = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign front_pv = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign ptr_nx   = (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;

	always_comb begin
		sum = (AW + 1)'(front_q) + (AW + 1)'(cnt_q);
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		tail = sum[AW-1:0];
	end

	always_comb begin
		imm_vld    = 1'b0;
		imm_status = STAT_OK;
		ram_we     = 1'b0;
		ram_waddr  = front_q;
		ram_wdata  = ram_rdata;
		ram_re     = 1'b0;
		ram_raddr  = front_q;
		if (take) begin
			case (head.entry.op)
				OP_PUSH: begin
					imm_vld = 1'b1;
					if (is_full) begin
						imm_status = STAT_FULL;
					end else begin
						ram_we    = 1'b1;
						ram_waddr = mode_q ? tail : front_pv;
						ram_wdata = head.entry.value;
					end
				end
				OP_PRINT: begin
					if (is_empty) begin
						imm_vld = 1'b1;
					end else begin
						ram_re = 1'b1;
					end
				end
				OP_PEEK: begin
					if (is_empty) begin
						imm_vld    = 1'b1;
						imm_status = STAT_EMPTY;
					end else begin
						ram_re = 1'b1;
					end
				end
				OP_POP: begin
					imm_vld = 1'b1;
					if (is_empty) begin
						imm_status = STAT_EMPTY;
					end
				end
				OP_SWAP: begin
					if (cnt_q < CW'(2)) begin
						imm_vld    = 1'b1;
						imm_status = STAT_SHORT;
					end else begin
						ram_re = 1'b1;
					end
				end
				default: imm_vld = 1'b1;
			endcase
		end else begin
			case (state_q)
				S_PRINT: begin
					ram_re    = 1'b1;
					ram_raddr = ptr_q;
				end
				S_SWAP_B: begin
					ram_re    = 1'b1;
					ram_raddr = front_nx;
				end
				S_SWAP_W1: begin
					ram_we    = 1'b1;
					ram_waddr = front_q;
					ram_wdata = ram_rdata;
				end
				S_SWAP_W2: begin
					imm_vld   = 1'b1;
					ram_we    = 1'b1;
					ram_waddr = front_nx;
					ram_wdata = tmp_q;
				end
				default: ;
			endcase
		end
	end

	sqe_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_SWAP_B) begin
			tmp_q <= ram_rdata;
		end
		if (pend_s1) begin
			rsp_q.data     <= $signed(ram_rdata);
			rsp_q.has_data <= 1'b1;
			rsp_q.status   <= STAT_OK;
			rsp_q.last     <= pend_last_s1;
		end else begin
			rsp_q.data     <= '0;
			rsp_q.has_data <= 1'b0;
			rsp_q.status   <= imm_status;
			rsp_q.last     <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			front_q      <= '0;
			cnt_q        <= '0;
			mode_q       <= 1'b0;
			ptr_q        <= '0;
			rem_q        <= '0;
			pend_s1      <= 1'b0;
			pend_last_s1 <= 1'b0;
			rsp_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			rsp_vld_q    <= pend_s1 || imm_vld;
			pend_s1      <= 1'b0;
			pend_last_s1 <= 1'b0;
			if (take) begin
				case (head.entry.op)
					OP_PUSH: begin
						if (!is_full) begin
							cnt_q <= cnt_q + 1'b1;
							if (!mode_q) begin
								front_q <= front_pv;
							end
						end
					end
					OP_PRINT: begin
						if (!is_empty) begin
							pend_s1      <= 1'b1;
							pend_last_s1 <= (cnt_q == CW'(1));
							ptr_q        <= front_nx;
							rem_q        <= cnt_q - 1'b1;
							if (cnt_q != CW'(1)) begin
								state_q <= S_PRINT;
							end
						end
					end
					OP_PEEK: begin
						if (!is_empty) begin
							pend_s1      <= 1'b1;
							pend_last_s1 <= 1'b1;
						end
					end
					OP_POP: begin
						if (!is_empty) begin
							cnt_q   <= cnt_q - 1'b1;
							front_q <= front_nx;
						end
					end
					OP_SWAP: begin
						if (cnt_q >= CW'(2)) begin
							state_q <= S_SWAP_B;
						end
					end
					default: ;
				endcase
			end else begin
				case (state_q)
					S_PRINT: begin
						pend_s1      <= 1'b1;
						pend_last_s1 <= (rem_q == CW'(1));
						ptr_q        <= ptr_nx;
						rem_q        <= rem_q - 1'b1;
						if (rem_q == CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
					S_SWAP_B:  state_q <= S_SWAP_W1;
					S_SWAP_W1: state_q <= S_SWAP_W2;
					S_SWAP_W2: state_q <= S_IDLE;
					default:   state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_vld_q;

	assert property (@(posedge clk) disable iff (!arst_n) !(pend_s1 && imm_vld))
		else $error("Read result and direct result collide in one cycle.");

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULL_CNT)
		else $error("Entry count exceeds the store depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(take && head.entry.op == OP_PUSH && !is_full) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("Push did not raise the entry count.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PRINT) |-> (rem_q != '0 && !is_empty))
		else $error("Print sweep running with nothing left to read.");

endmodule

FILE: src/stack_queue_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_queue_engine_unit: bounded stack/queue store of signed 32-bit values
// Push, print all, peek, pop and swap on a ring of entries with a front, with
// status for empty, short and full conditions.
// ----------------------------------------------------------------------------
// Channel   Ports                      Transfer
// command   start, busy, cmd           start high and busy low at a clock edge
// result    rsp_valid, rsp             rsp_valid high for one cycle
// config    cfg_we, cfg_data           cfg_we high at a clock edge
//
// Push, pop and error results pass through the command queue and the result
// register; a peek result also passes through the registered memory read. Print
// all reads one entry per cycle through the single memory read port. Swap reads
// the front entry and the one behind it, then writes each into the other's place.
// A two-entry command queue keeps accepting while the back end works; busy rises
// only when it is full. Reset clears the store to empty and selects stack mode.
// ----------------------------------------------------------------------------
module stack_queue_engine_unit
	import sqe_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  sqe_cmd_t cmd,
	output logic     busy,
	input  logic     cfg_we,
	input  logic     cfg_data,
	output sqe_rsp_t rsp,
	output logic     rsp_valid
);

	sqe_head_t head;
	logic      head_pop;

	sqe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.busy     (busy),
		.head     (head),
		.head_pop (head_pop)
	);

	sqe_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.head      (head),
		.head_pop  (head_pop),
		.rsp       (rsp),
		.rsp_valid (rsp_valid)
	);

endmodule

FILE: tb/stack_queue_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_queue_engine_checker: response predictor and comparator
// Watches the command, configuration and response channels of the stack/queue
// engine. Every command transfer updates a private copy of the store and queues
// the responses it must produce; every response is compared field by field
// with the oldest one still awaited.
// ----------------------------------------------------------------------------
module stack_queue_engine_checker
	import sqe_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  sqe_cmd_t cmd,
	input  logic     cfg_we,
	input  logic     cfg_data,
	input  logic     rsp_valid,
	input  sqe_rsp_t rsp,
	output int       fail_count,
	output int       pending,
	output int       rsp_checked
);

	logic signed [31:0] store [DEPTH];
	int                 head;
	int                 fill;
	logic               queue_mode;
	sqe_rsp_t           awaited_rsp [$];
	int                 errors = 0;
	int                 checked = 0;

	task automatic apply_command(input sqe_cmd_t c);
		sqe_rsp_t           r;
		logic signed [31:0] tmp;
		int                 nxt;
		r = '0;
		r.last = 1'b1;
		case (c.action)
			ACT_PUSH: begin
				if (fill == DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					if (queue_mode) begin
						store[(head + fill) % DEPTH] = c.value;
					end else begin
						head = (head + DEPTH - 1) % DEPTH;
						store[head] = c.value;
					end
					fill++;
				end
				awaited_rsp.push_back(r);
			end
			ACT_PRINT: begin
				if (fill == 0) begin
					awaited_rsp.push_back(r);
				end else begin
					for (int k = 0; k < fill; k++) begin
						r.data = store[(head + k) % DEPTH];
						r.has_data = 1'b1;
						r.last = (k == fill - 1);
						awaited_rsp.push_back(r);
					end
				end
			end
			ACT_PEEK: begin
				if (fill == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.data = store[head];
					r.has_data = 1'b1;
				end
				awaited_rsp.push_back(r);
			end
			ACT_POP: begin
				if (fill == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					head = (head + 1) % DEPTH;
					fill--;
				end
				awaited_rsp.push_back(r);
			end
			ACT_SWAP: begin
				if (fill < 2) begin
					r.status = STAT_SHORT;
				end else begin
					nxt = (head + 1) % DEPTH;
					tmp = store[head];
					store[head] = store[nxt];
					store[nxt] = tmp;
				end
				awaited_rsp.push_back(r);
			end
			default: begin
				awaited_rsp.push_back(r);
			end
		endcase
	endtask

	task automatic check_response(input sqe_rsp_t got);
		sqe_rsp_t exp;
		if (awaited_rsp.size() == 0) begin
			$error("Response with none awaited: data %0d, has_data %0b, status %0d, last %0b",
				got.data, got.has_data, got.status, got.last);
			errors++;
		end else begin
			exp = awaited_rsp.pop_front();
			checked++;
			if (got.data !== exp.data) begin
				$error("data: expected %0d, actual %0d", exp.data, got.data);
				errors++;
			end
			if (got.has_data !== exp.has_data) begin
				$error("has_data: expected %0b, actual %0b", exp.has_data, got.has_data);
				errors++;
			end
			if (got.status !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, got.status);
				errors++;
			end
			if (got.last !== exp.last) begin
				$error("last: expected %0b, actual %0b", exp.last, got.last);
				errors++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			fill = 0;
			queue_mode = 1'b0;
			awaited_rsp.delete();
		end else begin
			if (rsp_valid) begin
				check_response(rsp);
			end
			if (cfg_we) begin
				queue_mode = cfg_data;
			end
			if (start && !busy) begin
				apply_command(cmd);
			end
		end
		pending <= awaited_rsp.size();
		fail_count <= errors;
		rsp_checked <= checked;
	end

endmodule

FILE: tb/stack_queue_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_queue_engine_unit_tb: testbench of the stack/queue engine
// Drives directed commands covering empty, short and full store cases, a full
// fill in queue mode, then random command mixes in both push modes with random
// sender gaps in all but one phase. A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module stack_queue_engine_unit_tb;
	import sqe_pkg::*;

	localparam int DEPTH = 64;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 25;
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

	logic     clk;
	logic     arst_n;
	logic     start;
	sqe_cmd_t cmd;
	logic     busy;
	logic     cfg_we;
	logic     cfg_data;
	sqe_rsp_t rsp;
	logic     rsp_valid;

	int fail_count;
	int pending;
	int rsp_checked;
	int quiet_cycles = 0;
	int sent = 0;
	int directed = 0;
	bit gaps_on = 1'b1;

	stack_queue_engine_unit #(.DEPTH(DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.busy     (busy),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.rsp      (rsp),
		.rsp_valid(rsp_valid)
	);

	stack_queue_engine_checker #(.DEPTH(DEPTH)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.rsp_valid  (rsp_valid),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending),
		.rsp_checked(rsp_checked)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || rsp_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return 32'sh0000_0000;
			3:       return 32'shffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_action(input int push_pct);
		int         r;
		logic [2:0] spare;
		r = $urandom_range(0, 99);
		if (r < push_pct) begin
			return ACT_PUSH;
		end
		r = $urandom_range(0, 19);
		spare = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
		if (r < 7) begin
			return ACT_POP;
		end else if (r < 10) begin
			return ACT_PRINT;
		end else if (r < 14) begin
			return ACT_PEEK;
		end else if (r < 18) begin
			return ACT_SWAP;
		end
		return spare;
	endfunction

	task automatic send_cmd(input logic [2:0] act, input logic signed [31:0] val);
		sqe_cmd_t c;
		while (gaps_on && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			cmd.action <= 3'($urandom_range(0, 7));
			cmd.value <= $urandom;
			@(posedge clk);
		end
		c.action = act;
		c.value = val;
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		sent++;
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		cfg_we <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int push_pct);
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			send_cmd(pick_action(push_pct), pick_value());
		end
	endtask

	initial begin
		logic [2:0] spare;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		cfg_we <= 1'b0;
		cfg_data <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Stack mode from reset: error cases on an empty and a one-entry store.
		send_cmd(ACT_PEEK, 32'sd0);
		send_cmd(ACT_POP, 32'sd0);
		send_cmd(ACT_SWAP, 32'sd0);
		send_cmd(ACT_PRINT, 32'sd0);
		send_cmd(ACT_PUSH, 32'sh8000_0000);
		send_cmd(ACT_SWAP, 32'sd0);
		send_cmd(ACT_PUSH, 32'sh7fff_ffff);
		send_cmd(ACT_PUSH, 32'sd0);
		send_cmd(ACT_PUSH, 32'shffff_ffff);
		send_cmd(ACT_PRINT, 32'sd0);
		send_cmd(ACT_PEEK, 32'sd0);
		send_cmd(ACT_SWAP, 32'sd0);
		send_cmd(ACT_PRINT, 32'sd0);
		spare = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
		send_cmd(ACT_SPARE_FIRST, $urandom);
		send_cmd(ACT_SPARE_LAST, $urandom);
		send_cmd(spare, $urandom);
		send_cmd(ACT_POP, 32'sd0);
		send_cmd(ACT_PEEK, 32'sd0);
		send_cmd(ACT_POP, 32'sd0);
		send_cmd(ACT_POP, 32'sd0);
		send_cmd(ACT_POP, 32'sd0);
		send_cmd(ACT_POP, 32'sd0);
		send_cmd(ACT_PUSH, $urandom);
		send_cmd(ACT_POP, 32'sd0);
		directed = sent;
		wait_all_results();

		// Queue mode: fill the store, overflow it and wrap the ring.
		write_mode(1'b1);
		for (int i = 0; i < DEPTH; i++) begin
			send_cmd(ACT_PUSH, pick_value());
		end
		send_cmd(ACT_PUSH, pick_value());
		send_cmd(ACT_PRINT, 32'sd0);
		send_cmd(ACT_SWAP, 32'sd0);
		send_cmd(ACT_PEEK, 32'sd0);
		send_cmd(ACT_POP, 32'sd0);
		send_cmd(ACT_POP, 32'sd0);
		send_cmd(ACT_PUSH, pick_value());
		send_cmd(ACT_PUSH, pick_value());
		send_cmd(ACT_PUSH, pick_value());
		send_cmd(ACT_PRINT, 32'sd0);
		wait_all_results();

		write_mode(1'b0);
		random_phase(55);
		wait_all_results();

		write_mode(1'b1);
		gaps_on = 1'b0;
		random_phase(25);
		gaps_on = 1'b1;
		wait_all_results();

		write_mode(1'b0);
		random_phase(40);
		wait_all_results();

		write_mode(1'b1);
		random_phase(45);
		wait_all_results();

		$display("Sent %0d commands (%0d directed) in stack and queue mode, including a full",
			sent, directed);
		$display("store, ring wrap and every error status; %0d responses checked, %0d mismatches.",
			rsp_checked, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
